>>> sv/fla_pkg.sv
// Package for the flux-limited advection step core.
// Holds field widths, item kinds, limiter and register codes, and the controller states.
// Has no dependencies of its own.
package fla_pkg;

	localparam int DEF_GRID_CELLS = 256;
	localparam int CELL_W = 24;
	localparam int IDX_W = 8;
	localparam int KIND_W = 2;
	localparam int NU_W = 18;
	localparam int STEPS_W = 16;
	localparam int MODE_W = 3;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [MODE_W-1:0] RST_LIMITER = 3'd0;
	localparam logic signed [NU_W-1:0] RST_COURANT = 18'sd58982;
	localparam logic [STEPS_W-1:0] RST_STEPS = 16'd1;

	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		LIM_UPWIND = 3'd0,
		LIM_LAX_WENDROFF = 3'd1,
		LIM_BEAM_WARMING = 3'd2,
		LIM_MINMOD = 3'd3,
		LIM_SUPERBEE = 3'd4,
		LIM_MC = 3'd5,
		LIM_VAN_LEER = 3'd6,
		LIM_SPARE = 3'd7
	} limiter_t;

	typedef enum logic [1:0] {
		REG_LIMITER = 2'd0,
		REG_COURANT = 2'd1,
		REG_STEPS = 2'd2,
		REG_SPARE = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_FIN,
		S_ADV_C,
		S_LOAD_RD,
		S_LOAD_CAP,
		S_SH_RD,
		S_SH_CAP,
		S_FACE,
		S_DIV,
		S_TH,
		S_VL,
		S_MULF,
		S_UPD1,
		S_UPD2,
		S_UPD3
	} state_t;

endpackage

>>> sv/fla_if.sv
// Handshake channel interfaces of the flux-limited advection step core.
// fla_cmd_if carries input items, fla_rsp_if carries result items; both use fla_pkg.
interface fla_cmd_if;
	import fla_pkg::*;
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0] cell_index;
	logic signed [CELL_W-1:0] cell_value;
	modport source(output valid, kind, cell_index, cell_value, input ready);
	modport sink(input valid, kind, cell_index, cell_value, output ready);
endinterface

interface fla_rsp_if;
	import fla_pkg::*;
	logic valid;
	logic ready;
	logic signed [CELL_W-1:0] read_value;
	logic saturated;
	modport source(output valid, read_value, saturated, input ready);
	modport sink(input valid, read_value, saturated, output ready);
endinterface

>>> sv/flux_limited_advection_step_core.sv
// Top level of the flux-limited advection step core: grid memory, sequencer and datapath.
// Depends on fla_pkg and on the channel interfaces in fla_if.sv.
// Write and read items each give one result transfer.
// An advance item walks the whole grid once per step. Its pace is set by the bit-serial
// divider, which works out each theta and, with the van Leer limiter, each van Leer
// quotient one bit at a time, and by the single read port of the grid memory feeding a
// five-cell window.
module flux_limited_advection_step_core #(
	parameter int GRID_CELLS = fla_pkg::DEF_GRID_CELLS
) (
	input logic clk,
	input logic arst_n,
	fla_cmd_if.sink cmd,
	fla_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [fla_pkg::APB_ADDR_W-1:0] paddr,
	input logic [fla_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fla_pkg::APB_DATA_W-1:0] prdata,
	output logic pready
);
	import fla_pkg::*;

	localparam int CW = $clog2(GRID_CELLS);
	localparam int AW = CW + 1;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam logic [CW-1:0] LAST = CW'(GRID_CELLS - 1);
	localparam logic [CW-1:0] PRIME = CW'(GRID_CELLS - 2);

	state_t state_q, state_d;

	logic [MODE_W-1:0] mode_q;
	logic signed [NU_W-1:0] nu_q;
	logic [STEPS_W-1:0] steps_q;

	logic cur_q;
	logic idx_ok_q;
	logic out_valid_q;
	logic signed [CELL_W-1:0] res_val_q;
	logic res_sat_q;

	logic [CELL_W-1:0] mem [MEM_DEPTH];
	logic [CELL_W-1:0] rdata_q;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [CELL_W-1:0] wr_data;

	logic signed [CELL_W-1:0] w_q [5];
	logic [CW-1:0] rp_q, i_q;
	logic [2:0] load_cnt_q;
	logic [STEPS_W-1:0] step_cnt_q;
	logic fsel_q, vl_q, sat_q;
	logic signed [NU_W-1:0] c_q;

	logic [40:0] dq_q;
	logic [24:0] rem_q, dvs_q;
	logic dneg_q;
	logic [5:0] dcnt_q;

	logic signed [24:0] den_q;
	logic signed [20:0] phi_q;
	logic signed [29:0] dl_q, dr_q;
	logic signed [42:0] p1_q;
	logic signed [48:0] p2_q;

	logic acc, out_free, nu_neg;
	logic [CW-1:0] rp_nx;
	logic signed [24:0] fd_den, fd_num, dup;
	logic [24:0] abs_den, abs_num;
	logic [25:0] rem_sh;
	logic div_ge;
	logic [25:0] rem_nx;
	logic [19:0] th_mag;
	logic signed [20:0] th_c;
	logic signed [18:0] nu_x, anu, om;
	logic signed [37:0] cprod;
	logic signed [45:0] fprod;
	logic signed [30:0] ddiff;
	logic signed [49:0] total;
	logic signed [35:0] vnew;
	logic upd_sat;
	logic signed [CELL_W-1:0] vclamp;
	logic vl_start;
	logic last_step;

	function automatic logic signed [20:0] phi_of(input logic [MODE_W-1:0] mode,
			input logic signed [20:0] th);
		logic signed [22:0] t, t2, a, b, s, h, m, r, res;
		t = 23'(th);
		t2 = t <<< 1;
		a = (t2 < 0) ? 23'sd0 : ((t2 > 23'sd65536) ? 23'sd65536 : t2);
		b = (t < 23'sd131072) ? t : 23'sd131072;
		s = 23'sd65536 + t;
		h = (s + ((s < 0) ? 23'sd1 : 23'sd0)) >>> 1;
		m = (h < 23'sd131072) ? h : 23'sd131072;
		r = (m < t2) ? m : t2;
		case (limiter_t'(mode))
			LIM_LAX_WENDROFF: res = 23'sd65536;
			LIM_BEAM_WARMING: res = t;
			LIM_MINMOD: res = (t < 0) ? 23'sd0 : ((t > 23'sd65536) ? 23'sd65536 : t);
			LIM_SUPERBEE: res = (a > b) ? a : b;
			LIM_MC: res = (r < 0) ? 23'sd0 : r;
			default: res = 23'sd0;
		endcase
		return res[20:0];
	endfunction

	assign pready = 1'b1;
	assign out_free = !out_valid_q || rsp.ready;
	assign acc = cmd.valid && cmd.ready;
	assign nu_neg = nu_q[NU_W-1];
	assign rp_nx = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.read_value = res_val_q;
	assign rsp.saturated = res_sat_q;

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_LIMITER: prdata = 32'(mode_q);
			REG_COURANT: prdata = 32'(nu_q);
			REG_STEPS: prdata = 32'(steps_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RST_LIMITER;
			nu_q <= RST_COURANT;
			steps_q <= RST_STEPS;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_LIMITER: mode_q <= pwdata[MODE_W-1:0];
				REG_COURANT: nu_q <= pwdata[NU_W-1:0];
				REG_STEPS: steps_q <= pwdata[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		fd_den = fsel_q ? (25'(w_q[3]) - 25'(w_q[2])) : (25'(w_q[2]) - 25'(w_q[1]));
		if (nu_neg) begin
			fd_num = fsel_q ? (25'(w_q[4]) - 25'(w_q[3])) : (25'(w_q[3]) - 25'(w_q[2]));
			dup = 25'(w_q[3]) - 25'(w_q[2]);
		end else begin
			fd_num = fsel_q ? (25'(w_q[2]) - 25'(w_q[1])) : (25'(w_q[1]) - 25'(w_q[0]));
			dup = 25'(w_q[2]) - 25'(w_q[1]);
		end
		abs_den = fd_den[24] ? 25'(-fd_den) : 25'(fd_den);
		abs_num = fd_num[24] ? 25'(-fd_num) : 25'(fd_num);
		rem_sh = {rem_q, dq_q[40]};
		div_ge = rem_sh >= {1'b0, dvs_q};
		rem_nx = div_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		th_mag = (dq_q > 41'd524288) ? 20'd524288 : dq_q[19:0];
		th_c = dneg_q ? -$signed({1'b0, th_mag}) : $signed({1'b0, th_mag});
		vl_start = (limiter_t'(mode_q) == LIM_VAN_LEER) && (th_c > 21'sd0);
		nu_x = 19'(nu_q);
		anu = nu_x[18] ? -nu_x : nu_x;
		om = 19'sd65536 - anu;
		cprod = 38'(anu) * 38'(om);
		fprod = 46'(den_q) * 46'(phi_q);
		ddiff = 31'(dr_q) - 31'(dl_q);
		total = 50'(p1_q) + 50'(p2_q) + 50'sd32768;
		vnew = 36'(w_q[2]) - 36'($signed(total[49:16]));
		upd_sat = (vnew > 36'sd8388607) || (vnew < -36'sd8388608);
		if (vnew > 36'sd8388607) begin
			vclamp = 24'sh7FFFFF;
		end else if (vnew < -36'sd8388608) begin
			vclamp = 24'sh800000;
		end else begin
			vclamp = vnew[23:0];
		end
		last_step = (17'(step_cnt_q) + 17'd1) == 17'(steps_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (kind_t'(cmd.kind))
						KIND_READ: state_d = S_RD_WAIT;
						KIND_ADVANCE: state_d = (steps_q == '0) ? S_IDLE : S_ADV_C;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RD_WAIT: state_d = S_FIN;
			S_FIN: state_d = out_free ? S_IDLE : S_FIN;
			S_ADV_C: state_d = S_LOAD_RD;
			S_LOAD_RD: state_d = S_LOAD_CAP;
			S_LOAD_CAP: state_d = (load_cnt_q == 3'd4) ? S_FACE : S_LOAD_RD;
			S_SH_RD: state_d = S_SH_CAP;
			S_SH_CAP: state_d = S_FACE;
			S_FACE: begin
				if (fd_den != '0) begin
					state_d = S_DIV;
				end else if (fsel_q) begin
					state_d = S_UPD1;
				end
			end
			S_DIV: begin
				if (dcnt_q == 6'd40) begin
					state_d = vl_q ? S_VL : S_TH;
				end
			end
			S_TH: state_d = vl_start ? S_DIV : S_MULF;
			S_VL: state_d = S_MULF;
			S_MULF: state_d = fsel_q ? S_UPD1 : S_FACE;
			S_UPD1: state_d = S_UPD2;
			S_UPD2: state_d = S_UPD3;
			S_UPD3: begin
				if (i_q != LAST) begin
					state_d = S_SH_RD;
				end else begin
					state_d = last_step ? S_FIN : S_LOAD_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == S_IDLE) && out_free;
		rd_en = 1'b0;
		rd_addr = {cur_q, rp_q};
		wr_en = 1'b0;
		wr_addr = {~cur_q, i_q};
		wr_data = vclamp;
		case (state_q)
			S_IDLE: begin
				rd_addr = {cur_q, CW'(cmd.cell_index)};
				wr_addr = {cur_q, CW'(cmd.cell_index)};
				wr_data = cmd.cell_value;
				if (acc) begin
					rd_en = kind_t'(cmd.kind) == KIND_READ;
					wr_en = (kind_t'(cmd.kind) == KIND_WRITE)
						&& (32'(cmd.cell_index) < GRID_CELLS);
				end
			end
			S_LOAD_RD, S_SH_RD: rd_en = 1'b1;
			S_UPD3: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_UPD3) && (i_q == LAST)) begin
				cur_q <= ~cur_q;
			end
			if ((acc && (state_d == S_IDLE)) || ((state_q == S_FIN) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					res_val_q <= '0;
					res_sat_q <= 1'b0;
					idx_ok_q <= 32'(cmd.cell_index) < GRID_CELLS;
				end
			end
			S_RD_WAIT: res_val_q <= idx_ok_q ? $signed(rdata_q) : '0;
			S_ADV_C: begin
				c_q <= cprod[34:17];
				sat_q <= 1'b0;
				step_cnt_q <= '0;
				rp_q <= PRIME;
				load_cnt_q <= '0;
			end
			S_LOAD_CAP, S_SH_CAP: begin
				w_q[0] <= w_q[1];
				w_q[1] <= w_q[2];
				w_q[2] <= w_q[3];
				w_q[3] <= w_q[4];
				w_q[4] <= $signed(rdata_q);
				rp_q <= rp_nx;
				load_cnt_q <= load_cnt_q + 3'd1;
				fsel_q <= 1'b0;
				if (state_q == S_LOAD_CAP) begin
					i_q <= '0;
				end
			end
			S_FACE: begin
				den_q <= fd_den;
				dq_q <= {abs_num, 16'd0};
				dvs_q <= abs_den;
				rem_q <= '0;
				dcnt_q <= '0;
				dneg_q <= fd_num[24] ^ fd_den[24];
				vl_q <= 1'b0;
				if (fd_den == '0) begin
					if (fsel_q) begin
						dr_q <= '0;
					end else begin
						dl_q <= '0;
						fsel_q <= 1'b1;
					end
				end
			end
			S_DIV: begin
				rem_q <= rem_nx[24:0];
				dq_q <= {dq_q[39:0], div_ge};
				dcnt_q <= dcnt_q + 6'd1;
			end
			S_TH: begin
				phi_q <= phi_of(mode_q, th_c);
				dq_q <= 41'({th_c[19:0], 17'd0});
				dvs_q <= 25'(th_c[19:0]) + 25'd65536;
				rem_q <= '0;
				dcnt_q <= '0;
				dneg_q <= 1'b0;
				vl_q <= 1'b1;
			end
			S_VL: phi_q <= 21'(dq_q[17:0]);
			S_MULF: begin
				if (fsel_q) begin
					dr_q <= fprod[45:16];
				end else begin
					dl_q <= fprod[45:16];
					fsel_q <= 1'b1;
				end
			end
			S_UPD1: p1_q <= 43'(nu_q) * 43'(dup);
			S_UPD2: p2_q <= 49'(c_q) * 49'(ddiff);
			S_UPD3: begin
				sat_q <= sat_q | upd_sat;
				if (i_q != LAST) begin
					i_q <= i_q + 1'b1;
				end else begin
					step_cnt_q <= step_cnt_q + 1'b1;
					rp_q <= PRIME;
					load_cnt_q <= '0;
					res_val_q <= '0;
					res_sat_q <= sat_q | upd_sat;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> tb/sv/flux_limited_advection_step_core_test.sv
// Testbench of the flux-limited advection step core: fills the grid, then runs
// phases of random writes, reads and advances under several limiter settings.
// Depends on fla_pkg, fla_if.sv and the core; an in-bench predictor checks every result.
module flux_limited_advection_step_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import fla_pkg::*;

	localparam int CELLS = DEF_GRID_CELLS;
	localparam longint Q1 = 65536;
	localparam longint CMAX = 8388607;
	localparam longint CMIN = -8388608;
	localparam longint CYCLE_LIMIT = 8000000;

	typedef struct {
		logic signed [CELL_W-1:0] read_value;
		logic saturated;
	} cell_result_t;

	class grid_scoreboard;
		longint grid[2][CELLS];
		int cur;
		limiter_t mode;
		longint nu;
		int steps;
		cell_result_t pending[$];
		int mismatches;

		function new();
			cur = 0;
			mode = limiter_t'(RST_LIMITER);
			nu = longint'(RST_COURANT);
			steps = int'(RST_STEPS);
			mismatches = 0;
			foreach (grid[b, i]) grid[b][i] = 0;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
				REG_LIMITER: mode = limiter_t'(v[MODE_W-1:0]);
				REG_COURANT: nu = longint'($signed(v[NU_W-1:0]));
				REG_STEPS: steps = int'(v[STEPS_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint floor_div(longint x, longint d);
			if (x >= 0) return x / d;
			return -((-x + d - 1) / d);
		endfunction

		function longint lmin(longint a, longint b);
			return a < b ? a : b;
		endfunction

		function longint lmax(longint a, longint b);
			return a > b ? a : b;
		endfunction

		function longint phi(longint th);
			case (mode)
				LIM_LAX_WENDROFF: return Q1;
				LIM_BEAM_WARMING: return th;
				LIM_MINMOD: return lmax(0, lmin(th, Q1));
				LIM_SUPERBEE: return lmax(lmax(0, lmin(2 * th, Q1)), lmin(2 * Q1, th));
				LIM_MC: return lmax(0, lmin(lmin((Q1 + th) / 2, 2 * Q1), 2 * th));
				LIM_VAN_LEER: return th <= 0 ? 0 : (2 * th * Q1) / (Q1 + th);
				default: return 0;
			endcase
		endfunction

		function int prv(int i);
			return i == 0 ? CELLS - 1 : i - 1;
		endfunction

		function int nxt(int i);
			return i == CELLS - 1 ? 0 : i + 1;
		endfunction

		function longint face_delta(int f);
			int fm, up;
			longint den, num, th;
			fm = prv(f);
			den = grid[cur][f] - grid[cur][fm];
			if (den == 0) return 0;
			up = (nu >= 0) ? fm : nxt(f);
			num = grid[cur][up] - grid[cur][prv(up)];
			th = lmax(-524288, lmin(524288, (num * Q1) / den));
			return floor_div(den * phi(th), Q1);
		endfunction

		function bit advance_once();
			longint anu, c, dup, dl, dr, v;
			bit sat;
			int d;
			sat = 0;
			d = cur ^ 1;
			anu = nu < 0 ? -nu : nu;
			c = floor_div(anu * (Q1 - anu), 2 * Q1);
			for (int i = 0; i < CELLS; i++) begin
				dup = (nu >= 0) ? grid[cur][i] - grid[cur][prv(i)]
					: grid[cur][nxt(i)] - grid[cur][i];
				dl = face_delta(i);
				dr = face_delta(nxt(i));
				v = grid[cur][i] - floor_div(nu * dup + c * (dr - dl) + Q1 / 2, Q1);
				if (v > CMAX || v < CMIN) sat = 1;
				grid[d][i] = lmax(CMIN, lmin(CMAX, v));
			end
			cur = d;
			return sat;
		endfunction

		function void note_item(kind_t k, logic [IDX_W-1:0] ix, logic signed [CELL_W-1:0] v);
			cell_result_t r;
			r.read_value = '0;
			r.saturated = 0;
			case (k)
				KIND_WRITE: grid[cur][ix] = v;
				KIND_ADVANCE: for (int s = 0; s < steps; s++) if (advance_once()) r.saturated = 1;
				KIND_READ: r.read_value = CELL_W'(grid[cur][ix]);
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic signed [CELL_W-1:0] rv, logic sat);
			cell_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result transfer: %0d %0b", rv, sat);
				return;
			end
			e = pending.pop_front();
			if (rv !== e.read_value || sat !== e.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %0d/%0b, got %0d/%0b",
						e.read_value, e.saturated, rv, sat);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;
	logic pready;
	int send_idle, recv_idle;
	longint cycles;
	grid_scoreboard sb;

	fla_cmd_if cmd_ch();
	fla_rsp_if rsp_ch();

	flux_limited_advection_step_core dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		sb = new();
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			sb.note_item(kind_t'(cmd_ch.kind), cmd_ch.cell_index, cmd_ch.cell_value);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.read_value, rsp_ch.saturated);
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic reg_write(reg_idx_t r, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_item(kind_t k, logic [IDX_W-1:0] ix, logic signed [CELL_W-1:0] v);
		if ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= k;
		cmd_ch.cell_index <= ix;
		cmd_ch.cell_value <= v;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [CELL_W-1:0] pick_value();
		case ($urandom_range(5))
			0: return CELL_W'(CMAX);
			1: return CELL_W'(CMIN);
			2: return CELL_W'($signed(CELL_W'($urandom_range(2047))) - 1024);
			default: return CELL_W'($urandom);
		endcase
	endfunction

	initial begin
		longint nu_set[8];
		int adv_at[2];
		nu_set = '{65536, -65536, 0, 58982, -131072, 131071, -30001, 12345};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.kind <= KIND_WRITE;
		cmd_ch.cell_index <= '0;
		cmd_ch.cell_value <= '0;
		send_idle = 8;
		recv_idle = 55;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_STEPS, 32'd65535);
		reg_write(REG_STEPS, 32'd0);
		for (int i = 0; i < CELLS; i++)
			send_item(KIND_WRITE, IDX_W'(i), (i % 4 == 0) ? CELL_W'(CMAX)
				: (i % 4 == 1) ? CELL_W'(CMIN) : pick_value());
		send_item(KIND_READ, IDX_W'(0), '0);
		send_item(KIND_READ, IDX_W'(CELLS - 1), '0);
		send_item(KIND_NONE, 8'hFF, CELL_W'(-1));
		send_item(KIND_ADVANCE, IDX_W'(0), '0);
		send_item(KIND_READ, IDX_W'(1), '0);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				send_idle = 55;
				recv_idle = 8;
			end else if (p == 6) begin
				send_idle = 0;
				recv_idle = 0;
			end
			reg_write(REG_LIMITER, 32'(p));
			reg_write(REG_COURANT, 32'(nu_set[p] & 64'h3FFFF));
			reg_write(REG_STEPS, (p == 3) ? 32'd2 : 32'd1);
			adv_at[0] = $urandom_range(0, 30);
			adv_at[1] = $urandom_range(35, 66);
			for (int n = 0; n < 67; n++) begin
				if (n == adv_at[0] || n == adv_at[1])
					send_item(KIND_ADVANCE, IDX_W'($urandom), CELL_W'($urandom));
				else if ($urandom_range(19) == 0)
					send_item(KIND_NONE, IDX_W'($urandom), CELL_W'($urandom));
				else if ($urandom_range(1))
					send_item(KIND_WRITE, IDX_W'($urandom), pick_value());
				else
					send_item(KIND_READ, IDX_W'($urandom), CELL_W'($urandom));
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
